[design/rtp_pkg.sv]
// Shared types and constants of the rectangular-to-polar CORDIC pipeline.
// No dependencies; used by every module of the block.
package rtp_pkg;

	// Datapath width: samples are scaled to 40 bits, plus growth and sign.
	localparam int DataW   = 43;
	// Angle accumulator, radians * 2^30, holds +-pi plus the atan sum.
	localparam int AngW    = 35;
	localparam int TableLen = 24;
	localparam int MagW    = 16;
	localparam int PhW     = 16;

	localparam logic [21:0] GainQ22 = 22'd2547003;
	localparam logic signed [AngW-1:0] PiQ30    = 35'sd3373259426;
	localparam logic signed [AngW-1:0] NegPiQ30 = -35'sd3373259426;
	localparam logic signed [PhW-1:0] PiQ13        = 16'sd25736;
	localparam logic signed [PhW-1:0] NegPiQ13     = -16'sd25736;
	localparam logic signed [PhW-1:0] HalfPiQ13    = 16'sd12868;
	localparam logic signed [PhW-1:0] NegHalfPiQ13 = -16'sd12868;
	localparam logic [MagW-1:0] MagMax = 16'hFFFF;

	// atan(2^-i) * 2^30, truncated
	localparam logic [29:0] ATAN_Q30 [TableLen] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
		30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
		30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
		30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
		30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
	};

	// One item as it travels down the rotation chain.
	typedef struct packed {
		logic                    byp;      // axis case, result already known
		logic [MagW-1:0]         byp_mag;
		logic signed [PhW-1:0]   byp_ph;
		logic signed [DataW-1:0] x;
		logic signed [DataW-1:0] y;
		logic signed [AngW-1:0]  z;
	} cordic_t;

endpackage

[design/rtp_cell.sv]
// One CORDIC vectoring micro-rotation with its output register.
// Depends on rtp_pkg (cordic_t, atan table).
module rtp_cell #(
	parameter int Stage = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  rtp_pkg::cordic_t in_data,
	output logic            out_vld,
	output rtp_pkg::cordic_t out_data
);

	localparam logic signed [rtp_pkg::AngW-1:0] Ang =
		rtp_pkg::AngW'(rtp_pkg::ATAN_Q30[Stage]);

	logic signed [rtp_pkg::DataW-1:0] xs;
	logic signed [rtp_pkg::DataW-1:0] ys;
	rtp_pkg::cordic_t nxt;
	rtp_pkg::cordic_t data_q;
	logic vld_q;

	assign xs = in_data.x >>> Stage;
	assign ys = in_data.y >>> Stage;

	always_comb begin
		nxt = in_data;
		// rotate toward the real axis
		if (!in_data.y[rtp_pkg::DataW-1]) begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + Ang;
		end else begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - Ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_vld  = vld_q;
	assign out_data = data_q;

endmodule

[design/rtp_post.sv]
// Output stages: gain compensation in split partial products, rounding,
// magnitude saturation and phase clamp. Depends on rtp_pkg.
module rtp_post #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  rtp_pkg::cordic_t                  in_data,
	output logic                              done,
	output logic [rtp_pkg::MagW-1:0]          magnitude,
	output logic signed [rtp_pkg::PhW-1:0]    phase
);

	localparam int Guard = 40 - SAMPLE_BITS;
	localparam int AngW  = rtp_pkg::AngW;
	localparam int PrW   = 43;

	logic [PrW-1:0] lo_c;
	logic [PrW-1:0] hi_c;
	logic signed [AngW-1:0] zr;
	logic signed [AngW-18:0] ph_r;
	logic signed [rtp_pkg::PhW-1:0] ph_c;

	logic                           vld_s1;
	logic [PrW-1:0]                 lo_s1;
	logic [PrW-1:0]                 hi_s1;
	logic                           byp_s1;
	logic [rtp_pkg::MagW-1:0]       bmag_s1;
	logic signed [rtp_pkg::PhW-1:0] ph_s1;

	logic [63:0] sum;
	logic [63:0] shifted;

	logic                           vld_s2;
	logic [rtp_pkg::MagW-1:0]       mag_s2;
	logic signed [rtp_pkg::PhW-1:0] ph_s2;

	// x is never negative here; split it into two 21-bit halves
	assign lo_c = {22'b0, in_data.x[20:0]} * PrW'(rtp_pkg::GainQ22);
	assign hi_c = {22'b0, in_data.x[41:21]} * PrW'(rtp_pkg::GainQ22);

	assign zr   = in_data.z + AngW'(65536);
	assign ph_r = zr[AngW-1:17];

	always_comb begin
		if (in_data.byp) begin
			ph_c = in_data.byp_ph;
		end else if (ph_r > rtp_pkg::PiQ13) begin
			ph_c = rtp_pkg::PiQ13;
		end else if (ph_r < rtp_pkg::NegPiQ13) begin
			ph_c = rtp_pkg::NegPiQ13;
		end else begin
			ph_c = ph_r[rtp_pkg::PhW-1:0];
		end
	end

	assign sum = (64'(hi_s1) << 21) + 64'(lo_s1) + (64'(1) << (Guard + 21));
	assign shifted = sum >> (Guard + 22);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		lo_s1   <= lo_c;
		hi_s1   <= hi_c;
		byp_s1  <= in_data.byp;
		bmag_s1 <= in_data.byp_mag;
		ph_s1   <= ph_c;
		ph_s2   <= ph_s1;
		if (byp_s1) begin
			mag_s2 <= bmag_s1;
		end else if (|shifted[63:16]) begin
			mag_s2 <= rtp_pkg::MagMax;
		end else begin
			mag_s2 <= shifted[15:0];
		end
	end

	assign done      = vld_s2;
	assign magnitude = mag_s2;
	assign phase     = ph_s2;

endmodule

[design/rectangular_to_polar_core.sv]
// Rectangular-to-polar converter: entry stage, chain of CORDIC cells, output stages.
// Depends on rtp_pkg, rtp_cell and rtp_post.
//
// Usage:
//   Drive real_part and imag_part (signed, SAMPLE_BITS wide) and raise start for
//   one cycle per item. busy stays low: an item is taken in every cycle, so
//   a new complex bin may be offered on each clock.
//   Each item gives one result: magnitude (unsigned, input scale) and phase
//   (signed Q3.13 radians, -pi..pi), shown for exactly one cycle with done high.
//   The pipeline holds one entry stage that folds the left half plane and flags
//   the axis cases, one cell per micro-rotation, a partial-product stage for the
//   gain multiply and a sum/round stage.
//   Throughput is one item per cycle, set by the cell chain that advances
//   every clock.
//   The receiver cannot stall; results must be taken when done is high.
//   Reset (arst_n low) drops all items in flight; no done follows until new
//   items enter. The block keeps no other state.
module rectangular_to_polar_core #(
	parameter int CORDIC_ITERATIONS = 16,
	parameter int SAMPLE_BITS       = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [SAMPLE_BITS-1:0]        real_part,
	input  logic signed [SAMPLE_BITS-1:0]        imag_part,
	output logic                                 done,
	output logic [rtp_pkg::MagW-1:0]             magnitude,
	output logic signed [rtp_pkg::PhW-1:0]       phase
);

	localparam int Guard = 40 - SAMPLE_BITS;
	localparam int DataW = rtp_pkg::DataW;
	localparam int Lat   = CORDIC_ITERATIONS + 3;

	logic signed [DataW-1:0] re_w;
	logic signed [DataW-1:0] im_w;
	logic [SAMPLE_BITS-1:0]  re_abs;
	logic [SAMPLE_BITS-1:0]  im_abs;
	logic [32:0]             ax_abs;
	logic                    re_zero;
	logic                    im_zero;
	rtp_pkg::cordic_t        ent_c;

	logic                    vld_s1;
	rtp_pkg::cordic_t        ent_s1;

	logic                    chain_vld  [CORDIC_ITERATIONS+1];
	rtp_pkg::cordic_t        chain_data [CORDIC_ITERATIONS+1];

	assign busy = 1'b0;

	assign re_w    = DataW'(real_part);
	assign im_w    = DataW'(imag_part);
	assign re_zero = (real_part == '0);
	assign im_zero = (imag_part == '0);
	assign re_abs  = real_part[SAMPLE_BITS-1] ? SAMPLE_BITS'(-real_part)
		: SAMPLE_BITS'(real_part);
	assign im_abs  = imag_part[SAMPLE_BITS-1] ? SAMPLE_BITS'(-imag_part)
		: SAMPLE_BITS'(imag_part);
	assign ax_abs  = im_zero ? 33'(re_abs) : 33'(im_abs);

	always_comb begin
		ent_c.byp     = re_zero || im_zero;
		ent_c.byp_mag = (ax_abs > 33'(rtp_pkg::MagMax)) ? rtp_pkg::MagMax : ax_abs[15:0];
		if (im_zero) begin
			ent_c.byp_ph = real_part[SAMPLE_BITS-1] ? rtp_pkg::PiQ13 : '0;
		end else begin
			ent_c.byp_ph = imag_part[SAMPLE_BITS-1] ? rtp_pkg::NegHalfPiQ13
				: rtp_pkg::HalfPiQ13;
		end
		// fold the left half plane by pi
		if (real_part[SAMPLE_BITS-1]) begin
			ent_c.x = -(re_w <<< Guard);
			ent_c.y = -(im_w <<< Guard);
			ent_c.z = imag_part[SAMPLE_BITS-1] ? rtp_pkg::NegPiQ30 : rtp_pkg::PiQ30;
		end else begin
			ent_c.x = re_w <<< Guard;
			ent_c.y = im_w <<< Guard;
			ent_c.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1 <= ent_c;
	end

	assign chain_vld[0]  = vld_s1;
	assign chain_data[0] = ent_s1;

	for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
		rtp_cell #(
			.Stage(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (chain_vld[i]),
			.in_data (chain_data[i]),
			.out_vld (chain_vld[i+1]),
			.out_data(chain_data[i+1])
		);
	end

	rtp_post #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (chain_vld[CORDIC_ITERATIONS]),
		.in_data  (chain_data[CORDIC_ITERATIONS]),
		.done     (done),
		.magnitude(magnitude),
		.phase    (phase)
	);

	a_lat : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##Lat done)
		else $error("item accepted without a result after the pipeline latency");

	a_no_extra : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, Lat))
		else $error("result without a matching accepted item");

	a_ph_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (phase <= rtp_pkg::PiQ13 && phase >= rtp_pkg::NegPiQ13))
		else $error("phase outside -pi..pi");

	a_pos_axis : assert property (@(posedge clk) disable iff (!arst_n)
		(start && im_zero && !real_part[SAMPLE_BITS-1]) |-> ##Lat (done && phase == '0))
		else $error("positive real axis item gave nonzero phase");

endmodule
